>>> src/mfos_pkg.sv
// ----------------------------------------------------------------------------
// mfos_pkg: shared types and constants
// Request and status codes, field widths and the statistics bundle passed
// from the controller to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mfos_pkg;

    localparam int FILL_W  = 7;   // fill, peak and queue size width
    localparam int COUNT_W = 32;  // overflow counter width
    localparam int WORD_W  = 64;  // message word on the stream ports
    localparam int SIZE_MAX = (1 << FILL_W) - 1;

    typedef logic [1:0] req_t;
    localparam req_t REQ_ENQUEUE = 2'd0;
    localparam req_t REQ_DEQUEUE = 2'd1;
    localparam req_t REQ_CLEAR   = 2'd2;
    localparam req_t REQ_NOP     = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_FULL     = 2'd1;
    localparam status_t ST_EMPTY    = 2'd2;
    localparam status_t ST_DISABLED = 2'd3;

    // configuration register indexes
    typedef logic cfg_idx_t;
    localparam cfg_idx_t CFG_QUEUE_SIZE  = 1'b0;
    localparam cfg_idx_t CFG_ENQ_ENABLE  = 1'b1;

    localparam logic [FILL_W-1:0] QUEUE_SIZE_RESET = 7'd64;

    // post-request statistics from the controller
    typedef struct packed {
        status_t              status;
        logic                 deq_ok;
        logic [FILL_W-1:0]    fill;
        logic [FILL_W-1:0]    peak;
        logic                 ovf_mark;
        logic [COUNT_W-1:0]   ovf_count;
        logic                 is_empty;
        logic                 is_full;
    } stat_t;

endpackage

`default_nettype wire

>>> src/mfos_store.sv
// ----------------------------------------------------------------------------
// mfos_store: message word memory
// Single-port synchronous RAM, one write and/or one read per cycle at one address,
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mfos_store #(
    parameter int DEPTH     = 64,
    parameter int ELEM_BITS = 64
) (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   addr,
    input  wire logic [ELEM_BITS-1:0]       wdata,
    output logic      [ELEM_BITS-1:0]       rdata
);

    logic [ELEM_BITS-1:0] mem [DEPTH];
    logic [ELEM_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/mfos_ctrl.sv
// ----------------------------------------------------------------------------
// mfos_ctrl: queue pointers, counters and request decode
// Updates pointers, fill, high-water and overflow statistics on each
// request and drives the memory access.
// ----------------------------------------------------------------------------
`default_nettype none

module mfos_ctrl
    import mfos_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int ELEM_BITS = 64
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       req_fire,
    input  wire req_t                       req_type,
    input  wire logic [WORD_W-1:0]          write_data,
    input  wire logic [FILL_W-1:0]          queue_size,
    input  wire logic                       enqueue_enable,
    output logic                            mem_we,
    output logic                            mem_re,
    output logic [$clog2(DEPTH)-1:0]        mem_addr,
    output logic [ELEM_BITS-1:0]            mem_wdata,
    output stat_t                           stat
);

    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CMP_W     = (PTR_W + 1 > FILL_W) ? PTR_W + 1 : FILL_W;
    localparam int DEPTH_CAP = (DEPTH > SIZE_MAX) ? SIZE_MAX : DEPTH;

    logic [PTR_W-1:0]   read_pos_reg,  read_pos_next;
    logic [PTR_W-1:0]   write_pos_reg, write_pos_next;
    logic [FILL_W-1:0]  fill_reg,      fill_next;
    logic [FILL_W-1:0]  peak_reg,      peak_next;
    logic               ovf_mark_reg,  ovf_mark_next;
    logic [COUNT_W-1:0] ovf_count_reg, ovf_count_next;
    status_t            status_reg,    status_next;
    logic               deq_ok_reg,    deq_ok_next;
    logic [FILL_W-1:0]  size_eff;
    logic [FILL_W-1:0]  fill_inc;

    // next ring position, wrapping at the effective size
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0]  pos,
                                                 input logic [FILL_W-1:0] size);
        logic [CMP_W-1:0] n;
        begin
            n = CMP_W'(pos) + CMP_W'(1);
            return (n >= CMP_W'(size)) ? '0 : n[PTR_W-1:0];
        end
    endfunction

    always_comb begin
        if (queue_size == '0) begin
            size_eff = FILL_W'(1);
        end else if (32'(queue_size) > 32'(DEPTH_CAP)) begin
            size_eff = FILL_W'(DEPTH_CAP);
        end else begin
            size_eff = queue_size;
        end
    end

    assign fill_inc = fill_reg + FILL_W'(1);

    always_comb begin
        read_pos_next  = read_pos_reg;
        write_pos_next = write_pos_reg;
        fill_next      = fill_reg;
        peak_next      = peak_reg;
        ovf_mark_next  = ovf_mark_reg;
        ovf_count_next = ovf_count_reg;
        status_next    = status_reg;
        deq_ok_next    = deq_ok_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = write_pos_reg;
        mem_wdata      = write_data[ELEM_BITS-1:0];

        if (req_fire) begin
            status_next = ST_OK;
            deq_ok_next = 1'b0;
            unique case (req_type)
                REQ_ENQUEUE: begin
                    if (!enqueue_enable) begin
                        status_next = ST_DISABLED;
                    end else if (fill_reg >= size_eff) begin
                        status_next   = ST_FULL;
                        ovf_mark_next = 1'b1;
                        if (ovf_count_reg != '1) begin
                            ovf_count_next = ovf_count_reg + COUNT_W'(1);
                        end
                    end else begin
                        // empty queue restarts reading at the write pointer
                        if (fill_reg == '0) begin
                            read_pos_next = write_pos_reg;
                        end
                        mem_we         = 1'b1;
                        write_pos_next = advance(write_pos_reg, size_eff);
                        fill_next      = fill_inc;
                        if (peak_reg < fill_inc) begin
                            peak_next = fill_inc;
                        end
                    end
                end
                REQ_DEQUEUE: begin
                    if (fill_reg == '0) begin
                        status_next = ST_EMPTY;
                    end else begin
                        mem_re        = 1'b1;
                        mem_addr      = read_pos_reg;
                        deq_ok_next   = 1'b1;
                        read_pos_next = advance(read_pos_reg, size_eff);
                        fill_next     = fill_reg - FILL_W'(1);
                    end
                end
                REQ_CLEAR: begin
                    read_pos_next  = '0;
                    write_pos_next = '0;
                    fill_next      = '0;
                    peak_next      = '0;
                    ovf_mark_next  = 1'b0;
                    ovf_count_next = '0;
                end
                REQ_NOP: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_pos_reg  <= '0;
            write_pos_reg <= '0;
            fill_reg      <= '0;
            peak_reg      <= '0;
            ovf_mark_reg  <= 1'b0;
            ovf_count_reg <= '0;
            status_reg    <= ST_OK;
            deq_ok_reg    <= 1'b0;
        end else begin
            read_pos_reg  <= read_pos_next;
            write_pos_reg <= write_pos_next;
            fill_reg      <= fill_next;
            peak_reg      <= peak_next;
            ovf_mark_reg  <= ovf_mark_next;
            ovf_count_reg <= ovf_count_next;
            status_reg    <= status_next;
            deq_ok_reg    <= deq_ok_next;
        end
    end

    // registers hold the post-request values in the cycle after the request
    always_comb begin
        stat.status    = status_reg;
        stat.deq_ok    = deq_ok_reg;
        stat.fill      = fill_reg;
        stat.peak      = peak_reg;
        stat.ovf_mark  = ovf_mark_reg;
        stat.ovf_count = ovf_count_reg;
        stat.is_empty  = (fill_reg == '0);
        stat.is_full   = (fill_reg >= size_eff);
    end

endmodule

`default_nettype wire

>>> src/message_fifo_with_overflow_stats.sv
// ----------------------------------------------------------------------------
// message_fifo_with_overflow_stats: ring-buffer message queue with statistics
// Enqueue, dequeue, clear and no-op requests on a stream port, one result each.
// ----------------------------------------------------------------------------
// In the accept cycle of a request the controller updates the pointers and
// counters and issues the single memory access (write on enqueue, read on
// dequeue); then, once the output register is free or being drained, the
// registered read data and the post-request statistics are loaded into it.
// A new request is accepted while a finished result still waits in the
// output register; a second one waits until that register is taken.
// Configuration writes are always accepted and should only be issued while
// no request is in flight. Entries past a shrunk queue size that were never
// written return undefined data if dequeued.
// ----------------------------------------------------------------------------
`default_nettype none

module message_fifo_with_overflow_stats
    import mfos_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int ELEM_BITS = 64
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,

    // request channel
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [63:0]    s_tdata,    // write_data[63:0]
    input  wire logic [1:0]     s_tuser,    // req_type[1:0]

    // result channel
    output logic                m_tvalid,
    input  wire logic           m_tready,
    // read_data[63:0], fill_count[70:64], high_water[77:71],
    // overflow_seen[78], overflow_total[110:79], is_empty[111],
    // is_full[112], zero pad[119:113]
    output logic [119:0]        m_tdata,
    output logic [1:0]          m_tuser,    // status[1:0]

    // configuration write channel
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic           cfg_index,  // 0 queue_size, 1 enqueue_enable
    input  wire logic [6:0]     cfg_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int OUT_W = 120;

    // one-hot sequencer: idle, or loading a result from the memory
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOAD = 2'b10
    } fsm_state_t;

    fsm_state_t             state_reg, state_next;
    logic [FILL_W-1:0]      queue_size_reg;
    logic                   enq_enable_reg;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg;
    status_t                out_user_reg;

    logic                   req_fire;
    logic                   out_load;
    logic                   mem_we;
    logic                   mem_re;
    logic [PTR_W-1:0]       mem_addr;
    logic [ELEM_BITS-1:0]   mem_wdata;
    logic [ELEM_BITS-1:0]   mem_rdata;
    logic [WORD_W-1:0]      read_word;
    stat_t                  stat;

    assign s_tready = (state_reg == S_IDLE);
    assign req_fire = s_tvalid && s_tready;
    // output register is free or being drained this cycle
    assign out_load = (state_reg == S_LOAD) && (!out_valid_reg || m_tready);

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queue_size_reg <= QUEUE_SIZE_RESET;
            enq_enable_reg <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_QUEUE_SIZE: queue_size_reg <= cfg_data;
                CFG_ENQ_ENABLE: enq_enable_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    mfos_ctrl #(
        .DEPTH     (DEPTH),
        .ELEM_BITS (ELEM_BITS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req_fire       (req_fire),
        .req_type       (s_tuser),
        .write_data     (s_tdata),
        .queue_size     (queue_size_reg),
        .enqueue_enable (enq_enable_reg),
        .mem_we         (mem_we),
        .mem_re         (mem_re),
        .mem_addr       (mem_addr),
        .mem_wdata      (mem_wdata),
        .stat           (stat)
    );

    // a write and a read of one entry never fall in the same cycle, as the
    // next request waits until the load state ends; no forwarding path is needed
    mfos_store #(
        .DEPTH     (DEPTH),
        .ELEM_BITS (ELEM_BITS)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // read data only on a successful dequeue
    assign read_word = stat.deq_ok ? WORD_W'(mem_rdata) : '0;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (req_fire) state_next = S_LOAD;
            S_LOAD: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {7'd0, stat.is_full, stat.is_empty, stat.ovf_count,
                             stat.ovf_mark, stat.peak, stat.fill, read_word};
            out_user_reg <= stat.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire
